>>> rtl/multi_timer_table_macros.svh
// Assertion macros shared by the timer table checker.
`ifndef MULTI_TIMER_TABLE_MACROS_SVH
`define MULTI_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mtt_pkg.sv
// Types, codes and sizes for the multiple timer table.
package mtt_pkg;

    localparam int TIMER_SLOTS = 64;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam int REQ_W   = 2;
    localparam int COUNT_W = 16;
    localparam int TAG_W   = 32;
    localparam int SIDX_W  = 7;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int OP_W    = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADARG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNAVAIL = 2'd2;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Work handed from front to back.
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
    localparam logic [OP_W-1:0] OP_REPLY   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0]   tag;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

endpackage

>>> rtl/mtt_front.sv
// Front end: request classification and a two-word command queue.
module mtt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [mtt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mtt_pkg::COUNT_W-1:0]  i_start_count,
    input  logic [mtt_pkg::TAG_W-1:0]    i_user_tag,
    input  logic [mtt_pkg::SIDX_W-1:0]   i_slot_index,
    input  logic                         i_pop,
    output logic                         o_busy,
    output logic                         o_cmd_valid,
    output mtt_pkg::t_cmd                o_cmd
);

    mtt_pkg::t_cmd                 r_q [mtt_pkg::Q_DEPTH];
    logic [mtt_pkg::Q_PTR_W-1:0]   r_wp;
    logic [mtt_pkg::Q_PTR_W-1:0]   r_rp;
    logic [mtt_pkg::Q_CNT_W-1:0]   r_cnt;
    mtt_pkg::t_cmd                 cls_cmd;
    logic                          cls_keep;
    logic                          push;

    always_comb begin
        cls_cmd.op     = mtt_pkg::OP_REPLY;
        cls_cmd.status = mtt_pkg::ST_OK;
        cls_cmd.count  = i_start_count;
        cls_cmd.tag    = i_user_tag;
        cls_cmd.slot   = mtt_pkg::SLOT_W'(i_slot_index);
        cls_keep       = 1'b1;
        unique case (i_req_type)
            mtt_pkg::REQ_CREATE: begin
                if (i_start_count == '0) begin
                    cls_cmd.status = mtt_pkg::ST_BADARG;
                end else begin
                    cls_cmd.op = mtt_pkg::OP_CREATE;
                end
            end
            mtt_pkg::REQ_DESTROY: begin
                if (i_slot_index >= mtt_pkg::SIDX_W'(mtt_pkg::TIMER_SLOTS)) begin
                    cls_cmd.status = mtt_pkg::ST_BADARG;
                end else begin
                    cls_cmd.op = mtt_pkg::OP_DESTROY;
                end
            end
            mtt_pkg::REQ_TICK: begin
                cls_cmd.op = mtt_pkg::OP_TICK;
            end
            default: begin
                // unused request code: drop
                cls_keep = 1'b0;
            end
        endcase
    end

    assign o_busy      = (r_cnt == mtt_pkg::Q_CNT_W'(mtt_pkg::Q_DEPTH));
    assign push        = start && !o_busy && cls_keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/mtt_back.sv
// Back end: slot table, free-slot walk, tick walk and result register.
module mtt_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  mtt_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic                         o_result_kind,
    output logic [mtt_pkg::STAT_W-1:0]   o_status,
    output logic [mtt_pkg::IDX_W-1:0]    o_timer_index,
    output logic [mtt_pkg::TAG_W-1:0]    o_expired_tag,
    output logic                         o_last_result
);

    localparam logic [2:0] BK_IDLE     = 3'd0;
    localparam logic [2:0] BK_CREATE   = 3'd1;
    localparam logic [2:0] BK_TICK     = 3'd2;
    localparam logic [2:0] BK_TICK_END = 3'd3;
    localparam logic [2:0] BK_FLUSH    = 3'd4;

    logic [mtt_pkg::COUNT_W-1:0]     r_ticks_mem [mtt_pkg::TIMER_SLOTS];
    logic [mtt_pkg::TAG_W-1:0]       r_tag_mem   [mtt_pkg::TIMER_SLOTS];
    logic [mtt_pkg::COUNT_W-1:0]     r_ticks_q;
    logic [mtt_pkg::TAG_W-1:0]       r_tag_q;

    logic [2:0]                      r_state, n_state;
    logic [mtt_pkg::SLOT_W-1:0]      r_scan, n_scan;
    mtt_pkg::t_cmd                   r_cmd, n_cmd;
    logic [mtt_pkg::TIMER_SLOTS-1:0] r_active, n_active;
    logic                            r_pv, n_pv;
    logic [mtt_pkg::SLOT_W-1:0]      r_pidx, n_pidx;
    logic                            r_hold_v, n_hold_v;
    logic [mtt_pkg::SLOT_W-1:0]      r_hold_idx, n_hold_idx;
    logic [mtt_pkg::TAG_W-1:0]       r_hold_tag, n_hold_tag;

    logic                            r_strobe, n_strobe;
    logic                            r_kind, n_kind;
    logic [mtt_pkg::STAT_W-1:0]      r_status, n_status;
    logic [mtt_pkg::IDX_W-1:0]       r_index, n_index;
    logic [mtt_pkg::TAG_W-1:0]       r_tag, n_tag;
    logic                            r_last, n_last;

    logic                            tk_we;
    logic [mtt_pkg::SLOT_W-1:0]      tk_addr;
    logic [mtt_pkg::COUNT_W-1:0]     tk_data;
    logic                            tg_we;
    logic                            scan_last;

    assign scan_last = (r_scan == mtt_pkg::SLOT_W'(mtt_pkg::TIMER_SLOTS - 1));
    assign o_pop     = (r_state == BK_IDLE) && i_cmd_valid;

    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_cmd      = r_cmd;
        n_active   = r_active;
        n_pv       = 1'b0;
        n_pidx     = r_scan;
        n_hold_v   = r_hold_v;
        n_hold_idx = r_hold_idx;
        n_hold_tag = r_hold_tag;
        n_strobe   = 1'b0;
        n_kind     = mtt_pkg::KIND_REPLY;
        n_status   = mtt_pkg::ST_OK;
        n_index    = '0;
        n_tag      = '0;
        n_last     = 1'b1;
        tk_we      = 1'b0;
        tk_addr    = r_scan;
        tk_data    = r_cmd.count;
        tg_we      = 1'b0;

        // Second tick stage: count read back for an active slot.
        // An expiry is held until the next one (or the end of the walk) shows
        // whether it is the last.
        if (r_pv) begin
            if (r_ticks_q <= mtt_pkg::COUNT_W'(1)) begin
                n_active[r_pidx] = 1'b0;
                if (r_hold_v) begin
                    n_strobe = 1'b1;
                    n_kind   = mtt_pkg::KIND_EXPIRY;
                    n_index  = mtt_pkg::IDX_W'(r_hold_idx);
                    n_tag    = r_hold_tag;
                    n_last   = 1'b0;
                end
                n_hold_v   = 1'b1;
                n_hold_idx = r_pidx;
                n_hold_tag = r_tag_q;
            end else begin
                tk_we   = 1'b1;
                tk_addr = r_pidx;
                tk_data = r_ticks_q - 1'b1;
            end
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd  = i_cmd;
                    n_scan = '0;
                    unique case (i_cmd.op)
                        mtt_pkg::OP_CREATE: n_state = BK_CREATE;
                        mtt_pkg::OP_TICK:   n_state = BK_TICK;
                        mtt_pkg::OP_DESTROY: begin
                            n_strobe = 1'b1;
                            n_index  = mtt_pkg::IDX_W'(i_cmd.slot);
                            if (r_active[i_cmd.slot]) begin
                                n_active[i_cmd.slot] = 1'b0;
                            end else begin
                                n_status = mtt_pkg::ST_UNAVAIL;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = i_cmd.status;
                        end
                    endcase
                end
            end
            BK_CREATE: begin
                if (!r_active[r_scan]) begin
                    tk_we            = 1'b1;
                    tg_we            = 1'b1;
                    n_active[r_scan] = 1'b1;
                    n_strobe         = 1'b1;
                    n_index          = mtt_pkg::IDX_W'(r_scan);
                    n_state          = BK_IDLE;
                end else if (scan_last) begin
                    n_strobe = 1'b1;
                    n_status = mtt_pkg::ST_UNAVAIL;
                    n_state  = BK_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            BK_TICK: begin
                n_pv = r_active[r_scan];
                if (scan_last) begin
                    n_state = BK_TICK_END;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            BK_TICK_END: begin
                n_state = BK_FLUSH;
            end
            BK_FLUSH: begin
                if (r_hold_v) begin
                    n_strobe = 1'b1;
                    n_kind   = mtt_pkg::KIND_EXPIRY;
                    n_index  = mtt_pkg::IDX_W'(r_hold_idx);
                    n_tag    = r_hold_tag;
                end
                n_hold_v = 1'b0;
                n_state  = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tk_we) begin
            r_ticks_mem[tk_addr] <= tk_data;
        end
        r_ticks_q <= r_ticks_mem[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (tg_we) begin
            r_tag_mem[r_scan] <= r_cmd.tag;
        end
        r_tag_q <= r_tag_mem[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_active <= '0;
            r_pv     <= 1'b0;
            r_hold_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_pv     <= n_pv;
            r_hold_v <= n_hold_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_cmd      <= n_cmd;
        r_pidx     <= n_pidx;
        r_hold_idx <= n_hold_idx;
        r_hold_tag <= n_hold_tag;
        r_kind     <= n_kind;
        r_status   <= n_status;
        r_index    <= n_index;
        r_tag      <= n_tag;
        r_last     <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_status      = r_status;
    assign o_timer_index = r_index;
    assign o_expired_tag = r_tag;
    assign o_last_result = r_last;

endmodule

>>> rtl/multi_timer_table.sv
// Top level of the multiple timer table.
// A table of 64 one-shot countdown timers. A request is taken when start is
// high and busy is low; busy rises only when the two-word command queue is
// full. Results come out one per cycle on o_strobe and must be taken as
// shown: the receiver cannot stall. A rejected create or destroy and a
// valid destroy answer straight from the result register once the back end
// reaches them. A create walks the slot table from slot 0 and takes the
// lowest free slot, or answers unavailable when the table is full. A tick
// walks all 64 slots through one shared decrementer and memory port, one
// slot a cycle; its expiry words leave in ascending slot order, each
// expiry being sent once the next one is found or the walk is done.
// Request code 3 is taken and dropped.
module multi_timer_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mtt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mtt_pkg::COUNT_W-1:0]  i_start_count,
    input  logic [mtt_pkg::TAG_W-1:0]    i_user_tag,
    input  logic [mtt_pkg::SIDX_W-1:0]   i_slot_index,
    output logic                         o_strobe,
    output logic                         o_result_kind,
    output logic [mtt_pkg::STAT_W-1:0]   o_status,
    output logic [mtt_pkg::IDX_W-1:0]    o_timer_index,
    output logic [mtt_pkg::TAG_W-1:0]    o_expired_tag,
    output logic                         o_last_result
);

    logic          cmd_valid;
    logic          cmd_pop;
    mtt_pkg::t_cmd cmd;

    mtt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_req_type    (i_req_type),
        .i_start_count (i_start_count),
        .i_user_tag    (i_user_tag),
        .i_slot_index  (i_slot_index),
        .i_pop         (cmd_pop),
        .o_busy        (busy),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    mtt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_pop         (cmd_pop),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_timer_index (o_timer_index),
        .o_expired_tag (o_expired_tag),
        .o_last_result (o_last_result)
    );

endmodule

>>> rtl/mtt_checker.sv
// Port-level checks for the multiple timer table, bound to the top level.
`include "multi_timer_table_macros.svh"

module mtt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_strobe,
    input logic                         o_result_kind,
    input logic [mtt_pkg::STAT_W-1:0]   o_status,
    input logic [mtt_pkg::IDX_W-1:0]    o_timer_index,
    input logic [mtt_pkg::TAG_W-1:0]    o_expired_tag,
    input logic                         o_last_result
);

    // a reply always closes its request
    `MTT_ASSERT_IMP(a_reply_last, i_clk, i_rst_n,
        o_strobe && (o_result_kind == mtt_pkg::KIND_REPLY), o_last_result,
        "reply word not marked last")

    `MTT_ASSERT_IMP(a_reply_tag_zero, i_clk, i_rst_n,
        o_strobe && (o_result_kind == mtt_pkg::KIND_REPLY), o_expired_tag == '0,
        "reply word carries a nonzero tag")

    `MTT_ASSERT_IMP(a_expiry_ok, i_clk, i_rst_n,
        o_strobe && (o_result_kind == mtt_pkg::KIND_EXPIRY), o_status == mtt_pkg::ST_OK,
        "expiry word with error status")

    // an error reply never names a slot, except destroy of a free slot; this checks the bad-argument case
    `MTT_ASSERT_IMP(a_badarg_index, i_clk, i_rst_n,
        o_strobe && (o_status == mtt_pkg::ST_BADARG), o_timer_index == '0,
        "bad-argument reply with nonzero index")

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (.*);
